// File: hdl/ird_pkg.sv
// Shared constants and table functions for the IR ring direction estimator.
`default_nettype none
package ird_pkg;

    localparam int INPUT_BITS    = 16;
    localparam int WINDOW_W      = 16;
    localparam int FIELD_W       = 16;
    localparam int COMP_W        = 17;
    localparam int TRIG_W        = 16;
    localparam int ANGLE_W       = 32;
    localparam int TABLE_STEPS   = 24;
    localparam int GAIN_W        = 30;
    localparam logic [GAIN_W-1:0] GAIN_Q30 = 30'd652032874;
    localparam logic [WINDOW_W-1:0] WINDOW_RESET = 16'd1666;

    // Arctangent of 2^-i in 2^32 units per turn.
    function automatic logic [ANGLE_W-1:0] atan_turn(input logic [4:0] i);
        logic [ANGLE_W-1:0] a;
        case (i)
            5'd0:    a = 32'd536870912;
            5'd1:    a = 32'd316933406;
            5'd2:    a = 32'd167458907;
            5'd3:    a = 32'd85004756;
            5'd4:    a = 32'd42667331;
            5'd5:    a = 32'd21354465;
            5'd6:    a = 32'd10679838;
            5'd7:    a = 32'd5340245;
            5'd8:    a = 32'd2670163;
            5'd9:    a = 32'd1335087;
            5'd10:   a = 32'd667544;
            5'd11:   a = 32'd333772;
            5'd12:   a = 32'd166886;
            5'd13:   a = 32'd83443;
            5'd14:   a = 32'd41722;
            5'd15:   a = 32'd20861;
            5'd16:   a = 32'd10430;
            5'd17:   a = 32'd5215;
            5'd18:   a = 32'd2608;
            5'd19:   a = 32'd1304;
            5'd20:   a = 32'd652;
            5'd21:   a = 32'd326;
            5'd22:   a = 32'd163;
            5'd23:   a = 32'd81;
            default: a = 32'd0;
        endcase
        return a;
    endfunction

    // Q1.15 {cos, sin} of a binary angle, for elaboration-time tables.
    function automatic logic [2*TRIG_W-1:0] unit_cs(input logic [ANGLE_W-1:0] theta);
        longint x;
        longint y;
        longint z;
        longint nx;
        longint c;
        longint s;
        logic [ANGLE_W-1:0] th;
        bit flip;
        th   = theta;
        flip = 1'b0;
        if (((th + 32'h4000_0000) & 32'h8000_0000) != 32'd0) begin
            th   = th - 32'h8000_0000;
            flip = 1'b1;
        end
        z = longint'($signed(th));
        x = longint'(GAIN_Q30);
        y = 0;
        for (int i = 0; i < TABLE_STEPS; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i);
                y  = y + (x >>> i);
                z  = z - longint'(atan_turn(5'(i)));
            end else begin
                nx = x + (y >>> i);
                y  = y - (x >>> i);
                z  = z + longint'(atan_turn(5'(i)));
            end
            x = nx;
        end
        if (flip) begin
            x = -x;
            y = -y;
        end
        c = (x + 16384) >>> 15;
        s = (y + 16384) >>> 15;
        if (c > 32767) c = 32767;
        if (c < -32767) c = -32767;
        if (s > 32767) s = 32767;
        if (s < -32767) s = -32767;
        return {c[TRIG_W-1:0], s[TRIG_W-1:0]};
    endfunction

endpackage
`default_nettype wire

// File: hdl/ird_front.sv
// Front end: per-sensor hit counters, window timing and snapshot push.
`default_nettype none
module ird_front #(
    parameter int NUM_SENSORS = 16,
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                                   aclk,
    input  wire logic                                   aresetn,
    input  wire logic                                   cfg_wr_en,
    input  wire logic [ird_pkg::WINDOW_W-1:0]           cfg_wr_data,
    input  wire logic                                   s_valid,
    output logic                                        s_ready,
    input  wire logic [ird_pkg::INPUT_BITS-1:0]         s_sensor_levels,
    input  wire logic                                   q_full,
    output logic                                        q_push,
    output logic [NUM_SENSORS*COUNT_WIDTH-1:0]          q_push_data
);
    import ird_pkg::*;

    logic [WINDOW_W-1:0]    window_reg;
    logic [WINDOW_W-1:0]    tick_reg;
    logic [WINDOW_W-1:0]    tick_next;
    logic [WINDOW_W-1:0]    limit;
    logic [COUNT_WIDTH-1:0] count_reg  [NUM_SENSORS];
    logic [COUNT_WIDTH-1:0] count_next [NUM_SENSORS];
    logic                   accept;
    logic                   window_end;

    assign s_ready    = !q_full;
    assign accept     = s_valid && s_ready;
    assign tick_next  = tick_reg + 1'b1;
    assign limit      = (window_reg == '0) ? WINDOW_W'(1) : window_reg;
    assign window_end = (tick_next >= limit);
    assign q_push     = accept && window_end;

    for (genvar k = 0; k < NUM_SENSORS; k++) begin : g_count
        if (k < INPUT_BITS) begin : g_live
            // count a low level, hold at full scale
            assign count_next[k] = (!s_sensor_levels[k] && !(&count_reg[k]))
                                   ? count_reg[k] + 1'b1 : count_reg[k];
        end else begin : g_dead
            assign count_next[k] = count_reg[k];
        end
        assign q_push_data[k*COUNT_WIDTH +: COUNT_WIDTH] = count_next[k];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= WINDOW_RESET;
        end else if (cfg_wr_en) begin
            window_reg <= cfg_wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tick_reg <= '0;
            for (int k = 0; k < NUM_SENSORS; k++) count_reg[k] <= '0;
        end else if (accept) begin
            tick_reg <= window_end ? '0 : tick_next;
            for (int k = 0; k < NUM_SENSORS; k++)
                count_reg[k] <= window_end ? '0 : count_next[k];
        end
    end

endmodule
`default_nettype wire

// File: hdl/ird_queue.sv
// Two-entry queue of count snapshots between front and back.
`default_nettype none
module ird_queue #(
    parameter int WIDTH = 256
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             push,
    input  wire logic [WIDTH-1:0] push_data,
    input  wire logic             pop,
    output logic                  full,
    output logic                  not_empty,
    output logic [WIDTH-1:0]      head_data
);
    logic [WIDTH-1:0] slot_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       fill_reg;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign head_data = slot_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) slot_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= !wr_ptr_reg;
            if (pop)  rd_ptr_reg <= !rd_ptr_reg;
            case ({push, pop})
                2'b10:   fill_reg <= fill_reg + 2'd1;
                2'b01:   fill_reg <= fill_reg - 2'd1;
                default: fill_reg <= fill_reg;
            endcase
        end
    end

endmodule
`default_nettype wire

// File: hdl/ird_back.sv
// Back end: weighted sum, vectoring CORDIC, magnitude scaling, result register.
`default_nettype none
module ird_back #(
    parameter int NUM_SENSORS  = 16,
    parameter int COUNT_WIDTH  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                                  aclk,
    input  wire logic                                  aresetn,
    input  wire logic                                  q_not_empty,
    input  wire logic [NUM_SENSORS*COUNT_WIDTH-1:0]    q_head_data,
    output logic                                       q_pop,
    output logic                                       m_valid,
    input  wire logic                                  m_ready,
    output logic [ird_pkg::FIELD_W-1:0]                m_direction,
    output logic [ird_pkg::FIELD_W-1:0]                m_magnitude,
    output logic signed [ird_pkg::COMP_W-1:0]          m_x_component,
    output logic signed [ird_pkg::COMP_W-1:0]          m_y_component
);
    import ird_pkg::*;

    localparam int IDX_W  = $clog2(NUM_SENSORS);
    localparam int STEP_W = $clog2(NUM_SENSORS + 1);
    localparam int ITER_W = $clog2(CORDIC_STEPS);
    localparam int PROD_W = COUNT_WIDTH + 1 + TRIG_W;
    localparam int ACC_W  = PROD_W + IDX_W + 1;
    localparam int CW     = 35;
    localparam int HALF_W = (CW - 1) / 2;
    localparam logic [ANGLE_W-1:0] ANG_STEP = 32'(64'h1_0000_0000 / NUM_SENSORS);
    localparam logic signed [ACC_W-1:0] LIM_POS = ACC_W'(65535);
    localparam logic signed [ACC_W-1:0] LIM_NEG = -ACC_W'(65535);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SUM  = 7'b0000010,
        S_PREP = 7'b0000100,
        S_ROT  = 7'b0001000,
        S_MAG0 = 7'b0010000,
        S_MAG1 = 7'b0100000,
        S_FIN  = 7'b1000000
    } state_t;

    logic signed [TRIG_W-1:0] cos_tab [NUM_SENSORS];
    logic signed [TRIG_W-1:0] sin_tab [NUM_SENSORS];

    for (genvar k = 0; k < NUM_SENSORS; k++) begin : g_tab
        localparam logic [2*TRIG_W-1:0] CS =
            ird_pkg::unit_cs(32'h3000_0000 - 32'(k) * ANG_STEP);
        assign cos_tab[k] = CS[2*TRIG_W-1:TRIG_W];
        assign sin_tab[k] = CS[TRIG_W-1:0];
    end

    state_t                    state_reg, state_next;
    logic [STEP_W-1:0]         step_reg, step_next;
    logic [ITER_W-1:0]         iter_reg, iter_next;
    logic signed [PROD_W-1:0]  px_reg, px_next, py_reg, py_next;
    logic signed [ACC_W-1:0]   ax_reg, ax_next, ay_reg, ay_next;
    logic signed [COMP_W-1:0]  xc_reg, xc_next, yc_reg, yc_next;
    logic signed [CW-1:0]      x_reg, x_next, y_reg, y_next;
    logic [ANGLE_W-1:0]        z_reg, z_next;
    logic [63:0]               mag_reg, mag_next;
    logic                      m_valid_reg, m_valid_next;
    logic [FIELD_W-1:0]        dir_reg, dir_next, magn_reg, magn_next;
    logic signed [COMP_W-1:0]  mx_reg, mx_next, my_reg, my_next;

    logic [IDX_W-1:0]          idx;
    logic [COUNT_WIDTH-1:0]    cnt;
    logic signed [ACC_W-1:0]   shx, shy;
    logic signed [COMP_W-1:0]  cx, cy;
    logic signed [CW-1:0]      x0, y0, dx, dy;
    logic [ANGLE_W-1:0]        atan_i;
    logic [CW-2:0]             xpos;
    logic [HALF_W-1:0]         mul_in;
    logic [HALF_W+GAIN_W-1:0]  mul_prod;
    logic [63:0]               mag_round;
    logic [19:0]               mag_top;
    logic                      out_free;

    assign idx      = step_reg[IDX_W-1:0];
    assign cnt      = q_head_data[idx*COUNT_WIDTH +: COUNT_WIDTH];
    assign shx      = ax_reg >>> 19;
    assign shy      = ay_reg >>> 19;
    assign cx       = (shx > LIM_POS) ? COMP_W'(65535) :
                      (shx < LIM_NEG) ? -COMP_W'(65535) : shx[COMP_W-1:0];
    assign cy       = (shy > LIM_POS) ? COMP_W'(65535) :
                      (shy < LIM_NEG) ? -COMP_W'(65535) : shy[COMP_W-1:0];
    assign x0       = {{(CW-COMP_W-14){cx[COMP_W-1]}}, cx, 14'b0};
    assign y0       = {{(CW-COMP_W-14){cy[COMP_W-1]}}, cy, 14'b0};
    assign dx       = x_reg >>> iter_reg;
    assign dy       = y_reg >>> iter_reg;
    assign atan_i   = atan_turn(5'(iter_reg));
    assign xpos     = x_reg[CW-1] ? '0 : x_reg[CW-2:0];
    // low half of the length first, high half on the next cycle
    assign mul_in   = (state_reg == S_MAG0) ? xpos[HALF_W-1:0] : xpos[CW-2:HALF_W];
    assign mul_prod = mul_in * GAIN_Q30;
    assign mag_round = mag_reg + 64'h0000_0800_0000_0000;
    assign mag_top  = mag_round[63:44];
    assign out_free = !m_valid_reg || m_ready;

    assign m_valid       = m_valid_reg;
    assign m_direction   = dir_reg;
    assign m_magnitude   = magn_reg;
    assign m_x_component = mx_reg;
    assign m_y_component = my_reg;

    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        iter_next    = iter_reg;
        px_next      = px_reg;
        py_next      = py_reg;
        ax_next      = ax_reg;
        ay_next      = ay_reg;
        xc_next      = xc_reg;
        yc_next      = yc_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        z_next       = z_reg;
        mag_next     = mag_reg;
        dir_next     = dir_reg;
        magn_next    = magn_reg;
        mx_next      = mx_reg;
        my_next      = my_reg;
        m_valid_next = m_valid_reg && !m_ready;
        q_pop        = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (q_not_empty) begin
                    step_next  = '0;
                    ax_next    = '0;
                    ay_next    = '0;
                    state_next = S_SUM;
                end
            end
            S_SUM: begin
                // multiply this sensor, add the previous product
                px_next = $signed({1'b0, cnt}) * cos_tab[idx];
                py_next = $signed({1'b0, cnt}) * sin_tab[idx];
                if (step_reg != '0) begin
                    ax_next = ax_reg + ACC_W'(px_reg);
                    ay_next = ay_reg + ACC_W'(py_reg);
                end
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_W'(NUM_SENSORS)) begin
                    q_pop      = 1'b1;
                    state_next = S_PREP;
                end
            end
            S_PREP: begin
                xc_next = cx;
                yc_next = cy;
                iter_next = '0;
                if (cx == '0 && cy == '0) begin
                    z_next     = '0;
                    mag_next   = '0;
                    state_next = S_FIN;
                end else if (cx[COMP_W-1]) begin
                    x_next     = -x0;
                    y_next     = -y0;
                    z_next     = 32'h8000_0000;
                    state_next = S_ROT;
                end else begin
                    x_next     = x0;
                    y_next     = y0;
                    z_next     = '0;
                    state_next = S_ROT;
                end
            end
            S_ROT: begin
                // rotate toward the x axis
                if (!y_reg[CW-1]) begin
                    x_next = x_reg + dy;
                    y_next = y_reg - dx;
                    z_next = z_reg + atan_i;
                end else begin
                    x_next = x_reg - dy;
                    y_next = y_reg + dx;
                    z_next = z_reg - atan_i;
                end
                iter_next = iter_reg + 1'b1;
                if (iter_reg == ITER_W'(CORDIC_STEPS - 1)) state_next = S_MAG0;
            end
            S_MAG0: begin
                mag_next   = 64'(mul_prod);
                state_next = S_MAG1;
            end
            S_MAG1: begin
                mag_next   = mag_reg + (64'(mul_prod) << HALF_W);
                state_next = S_FIN;
            end
            S_FIN: begin
                // hold until the result register is free
                if (out_free) begin
                    m_valid_next = 1'b1;
                    dir_next     = 16'((z_reg + 32'h0000_8000) >> 16);
                    magn_next    = (mag_top > 20'd65535) ? 16'hFFFF : mag_top[FIELD_W-1:0];
                    mx_next      = xc_reg;
                    my_next      = yc_reg;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            step_reg    <= '0;
            iter_reg    <= '0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
            step_reg    <= step_next;
            iter_reg    <= iter_next;
        end
    end

    always_ff @(posedge aclk) begin
        px_reg   <= px_next;
        py_reg   <= py_next;
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        xc_reg   <= xc_next;
        yc_reg   <= yc_next;
        x_reg    <= x_next;
        y_reg    <= y_next;
        z_reg    <= z_next;
        mag_reg  <= mag_next;
        dir_reg  <= dir_next;
        magn_reg <= magn_next;
        mx_reg   <= mx_next;
        my_reg   <= my_next;
    end

`ifndef NO_ASSERTIONS
    a_pop_has_entry: assert property (@(posedge aclk) disable iff (!aresetn)
        q_pop |-> q_not_empty)
        else $error("snapshot popped from empty queue");
    a_iter_range: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_ROT |-> iter_reg <= ITER_W'(CORDIC_STEPS - 1))
        else $error("rotation count out of range");
    a_zero_vector: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && mx_reg == '0 && my_reg == '0 |-> dir_reg == '0 && magn_reg == '0)
        else $error("zero vector gave nonzero angle or length");
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg && !m_ready |=> m_valid_reg)
        else $error("pending result dropped");
`endif

endmodule
`default_nettype wire

// File: hdl/ir_ring_direction_estimator_core.sv
// Top level of the IR ring direction estimator.
//
//  channel   ports                          beat
//  config    cfg_wr_en / cfg_wr_data        window length, no handshake
//  input     s_valid / s_ready              one sample of 16 sensor levels
//  output    m_valid / m_ready              direction, magnitude, x, y
//
// A sample beat is counted as it is accepted; s_ready drops only while both queue slots hold
// unprocessed windows. Each window then passes the start, summing, prepare, rotation,
// scaling and output states in that order; summing reuses one multiplier pair for every
// sensor, rotation reuses the single CORDIC stage, and the output state waits for a free
// result register. Reset (aresetn, synchronous) clears counters, tick count, queue and
// result valid and loads window length 1666.
`default_nettype none
module ir_ring_direction_estimator_core #(
    parameter int NUM_SENSORS  = 16,
    parameter int COUNT_WIDTH  = 16,
    parameter int CORDIC_STEPS = 16
) (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                cfg_wr_en,
    input  wire logic [ird_pkg::WINDOW_W-1:0]        cfg_wr_data,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic [ird_pkg::INPUT_BITS-1:0]      s_sensor_levels,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [ird_pkg::FIELD_W-1:0]              m_direction,
    output logic [ird_pkg::FIELD_W-1:0]              m_magnitude,
    output logic signed [ird_pkg::COMP_W-1:0]        m_x_component,
    output logic signed [ird_pkg::COMP_W-1:0]        m_y_component
);
    import ird_pkg::*;

    localparam int SNAP_W = NUM_SENSORS * COUNT_WIDTH;

    logic              q_push;
    logic [SNAP_W-1:0] q_push_data;
    logic              q_pop;
    logic              q_full;
    logic              q_not_empty;
    logic [SNAP_W-1:0] q_head_data;

    ird_front #(
        .NUM_SENSORS (NUM_SENSORS),
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .cfg_wr_en       (cfg_wr_en),
        .cfg_wr_data     (cfg_wr_data),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_sensor_levels (s_sensor_levels),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_push_data     (q_push_data)
    );

    ird_queue #(
        .WIDTH (SNAP_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (q_push_data),
        .pop       (q_pop),
        .full      (q_full),
        .not_empty (q_not_empty),
        .head_data (q_head_data)
    );

    ird_back #(
        .NUM_SENSORS  (NUM_SENSORS),
        .COUNT_WIDTH  (COUNT_WIDTH),
        .CORDIC_STEPS (CORDIC_STEPS)
    ) u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .q_not_empty   (q_not_empty),
        .q_head_data   (q_head_data),
        .q_pop         (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_direction   (m_direction),
        .m_magnitude   (m_magnitude),
        .m_x_component (m_x_component),
        .m_y_component (m_y_component)
    );

endmodule
`default_nettype wire

// File: verif/ird_checker.sv
// Checker for the IR ring direction estimator: predicts each window result and compares.
`timescale 1ns / 100ps
`default_nettype none
module ird_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        cfg_wr_en,
    input  wire logic [15:0] cfg_wr_data,
    input  wire logic        s_valid,
    input  wire logic        s_ready,
    input  wire logic [15:0] s_sensor_levels,
    input  wire logic        m_valid,
    input  wire logic        m_ready,
    input  wire logic [15:0] m_direction,
    input  wire logic [15:0] m_magnitude,
    input  wire logic signed [16:0] m_x_component,
    input  wire logic signed [16:0] m_y_component,
    output int               fail_count,
    output int               pending_count
);
    import ird_pkg::*;

    localparam int NSENS = 16;
    localparam logic [31:0] ATAN [0:23] = '{
        536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
        10679838, 5340245, 2670163, 1335087, 667544, 333772,
        166886, 83443, 41722, 20861, 10430, 5215,
        2608, 1304, 652, 326, 163, 81};

    typedef struct packed {
        logic [15:0]        direction;
        logic [15:0]        magnitude;
        logic signed [16:0] x_comp;
        logic signed [16:0] y_comp;
    } heading_t;

    heading_t    heading_q[$];
    logic [15:0] hit_count [NSENS];
    logic [15:0] ticks;
    logic [15:0] win_len;
    longint      cos_w [NSENS];
    longint      sin_w [NSENS];

    function automatic longint sat(input longint v, input longint lim);
        if (v > lim) return lim;
        if (v < -lim) return -lim;
        return v;
    endfunction

    // Table of sensor weights, built the same way: rotation CORDIC in Q2.30.
    function automatic void make_weight(input logic [31:0] theta, output longint c,
                                        output longint s);
        longint x, y, z, nx;
        bit flip;
        x = 652032874;
        y = 0;
        flip = 0;
        if (((theta + 32'h4000_0000) & 32'h8000_0000) != 0) begin
            theta = theta - 32'h8000_0000;
            flip = 1;
        end
        z = longint'($signed(theta));
        for (int i = 0; i < 24; i++) begin
            if (z >= 0) begin
                nx = x - (y >>> i); y = y + (x >>> i); z = z - longint'(ATAN[i]);
            end else begin
                nx = x + (y >>> i); y = y - (x >>> i); z = z + longint'(ATAN[i]);
            end
            x = nx;
        end
        if (flip) begin
            x = -x; y = -y;
        end
        c = sat((x + 16384) >>> 15, 32767);
        s = sat((y + 16384) >>> 15, 32767);
    endfunction

    function automatic heading_t close_window();
        heading_t h;
        longint sx, sy, x, y, nx;
        logic [31:0] z;
        logic [63:0] m;
        sx = 0;
        sy = 0;
        for (int k = 0; k < NSENS; k++) begin
            sx += longint'(hit_count[k]) * cos_w[k];
            sy += longint'(hit_count[k]) * sin_w[k];
        end
        sx = sat(sx >>> 19, 65535);
        sy = sat(sy >>> 19, 65535);
        h.x_comp = 17'(sx);
        h.y_comp = 17'(sy);
        if (sx == 0 && sy == 0) begin
            h.direction = 0;
            h.magnitude = 0;
            return h;
        end
        x = sx * 16384;
        y = sy * 16384;
        z = 0;
        if (x < 0) begin
            x = -x; y = -y; z = 32'h8000_0000;
        end
        for (int i = 0; i < 16; i++) begin
            if (y >= 0) begin
                nx = x + (y >>> i); y = y - (x >>> i); z = z + ATAN[i];
            end else begin
                nx = x - (y >>> i); y = y + (x >>> i); z = z - ATAN[i];
            end
            x = nx;
        end
        h.direction = 16'((z + 32'h8000) >> 16);
        if (x < 0) x = 0;
        m = (64'(x) * 64'd652032874 + (64'd1 << 43)) >> 44;
        h.magnitude = (m > 65535) ? 16'hFFFF : m[15:0];
        return h;
    endfunction

    initial begin
        for (int k = 0; k < NSENS; k++)
            make_weight(32'h3000_0000 - 32'(k) * 32'h1000_0000, cos_w[k], sin_w[k]);
    end

    always @(posedge aclk) begin
        heading_t got, want;
        logic [15:0] lim;
        if (!aresetn) begin
            for (int k = 0; k < NSENS; k++) hit_count[k] = 0;
            ticks = 0;
            win_len <= WINDOW_RESET;
            heading_q.delete();
            fail_count <= 0;
        end else begin
            if (cfg_wr_en) win_len <= cfg_wr_data;
            if (s_valid && s_ready) begin
                lim = (win_len == 0) ? 16'd1 : win_len;
                for (int k = 0; k < NSENS; k++)
                    if (!s_sensor_levels[k] && hit_count[k] != 16'hFFFF)
                        hit_count[k] = hit_count[k] + 1;
                ticks = ticks + 1;
                if (ticks >= lim) begin
                    heading_q.push_back(close_window());
                    for (int k = 0; k < NSENS; k++) hit_count[k] = 0;
                    ticks = 0;
                end
            end
            if (m_valid && m_ready) begin
                got = '{m_direction, m_magnitude, m_x_component, m_y_component};
                if (heading_q.size() == 0) begin
                    $display("%0t: result with no window pending: %p", $time, got);
                    fail_count <= fail_count + 1;
                end else begin
                    want = heading_q.pop_front();
                    if (got !== want) begin
                        $display("%0t: mismatch expected dir=%0d mag=%0d x=%0d y=%0d",
                                 $time, want.direction, want.magnitude, want.x_comp,
                                 want.y_comp);
                        $display("%0t:          actual   dir=%0d mag=%0d x=%0d y=%0d",
                                 $time, got.direction, got.magnitude, got.x_comp,
                                 got.y_comp);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
        pending_count = heading_q.size();
    end
endmodule
`default_nettype wire

// File: verif/tb_ir_ring_direction_estimator_core.sv
// Testbench top for the IR ring direction estimator: stimulus, idling and verdict.
`timescale 1ns / 100ps
`default_nettype none
module tb_ir_ring_direction_estimator_core;
    localparam int STALL_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 60;

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_wr_en = 0;
    logic [15:0] cfg_wr_data = 0;
    logic        s_valid = 0;
    logic        s_ready;
    logic [15:0] s_sensor_levels = 16'hFFFF;
    logic        m_valid;
    logic        m_ready = 0;
    logic [15:0] m_direction, m_magnitude;
    logic signed [16:0] m_x_component, m_y_component;
    int          fail_count, pending_count;
    int          idle_cycles = 0;
    bit          stall_mode = 0;

    always #2 aclk = ~aclk;

    ir_ring_direction_estimator_core u_top (
        .aclk, .aresetn, .cfg_wr_en, .cfg_wr_data, .s_valid, .s_ready, .s_sensor_levels,
        .m_valid, .m_ready, .m_direction, .m_magnitude, .m_x_component, .m_y_component);

    ird_checker u_chk (
        .aclk, .aresetn, .cfg_wr_en, .cfg_wr_data, .s_valid, .s_ready, .s_sensor_levels,
        .m_valid, .m_ready, .m_direction, .m_magnitude, .m_x_component, .m_y_component,
        .fail_count, .pending_count);

    // Receiver stall pattern: phases of always-ready and phases of random stalls.
    always @(posedge aclk) begin
        if ($urandom_range(0, 99) == 0) stall_mode <= ~stall_mode;
        m_ready <= stall_mode ? ($urandom_range(0, 3) != 0 && $urandom_range(0, 1)) : 1'b1;
    end

    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    int burst_left = 0;

    task automatic send_sample(input logic [15:0] levels);
        int gap;
        bit took;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_valid <= 0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_valid <= 1;
        s_sensor_levels <= levels;
        // look at ready mid-cycle, where it has settled
        do begin
            @(negedge aclk);
            took = s_ready;
            @(posedge aclk);
        end while (!took);
    endtask

    task automatic wait_idle();
        s_valid <= 0;
        @(posedge aclk);
        while (pending_count != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic set_window(input logic [15:0] len);
        wait_idle();
        cfg_wr_en <= 1;
        cfg_wr_data <= len;
        @(posedge aclk);
        cfg_wr_en <= 0;
    endtask

    function automatic logic [15:0] rand_levels();
        case ($urandom_range(0, 4))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2: return ~(16'h1 << $urandom_range(0, 15));
            3: return ~(16'h7 << $urandom_range(0, 13));
            default: return 16'($urandom);
        endcase
    endfunction

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        // Directed: single sensors, all on, none on (zero vector), window of zero.
        set_window(1);
        for (int k = 0; k < 16; k++) send_sample(~(16'h1 << k));
        send_sample(16'h0000);
        send_sample(16'hFFFF);
        send_sample(16'h00FF);
        send_sample(16'hFF00);
        set_window(0);
        send_sample(16'h5555);
        send_sample(16'hAAAA);
        // Lower window mid-window.
        set_window(20);
        repeat (10) send_sample(16'h0F0F);
        s_valid <= 0;
        cfg_wr_en <= 1;
        cfg_wr_data <= 16'd5;
        @(posedge aclk);
        cfg_wr_en <= 0;
        send_sample(16'hF0F0);
        send_sample(16'h0000);
        // Random windows, mostly short.
        for (int n = 0; n < 700; ) begin
            int len;
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60) : $urandom_range(0, 8);
            set_window(16'(len));
            for (int i = 0; i < 3 * (len == 0 ? 1 : len); i++, n++)
                send_sample(rand_levels());
        end
        wait_idle();
        if (fail_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: files.f
hdl/ird_pkg.sv
hdl/ird_front.sv
hdl/ird_queue.sv
hdl/ird_back.sv
hdl/ir_ring_direction_estimator_core.sv
verif/ird_checker.sv
verif/tb_ir_ring_direction_estimator_core.sv
